[hdl/fce_pkg.sv]
`timescale 1ns / 1ps

package fce_pkg;

    localparam int ENTRY_W        = 28;
    localparam int SECTOR_W       = 32;
    localparam int LEN_W          = 12;
    localparam int OP_W           = 2;
    localparam int STATUS_W       = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int USABLE_W       = 12;
    localparam int SPC_W          = 8;
    localparam int TBL_AW_MAX     = 20;

    localparam int DEF_TABLE_ENTRIES = 4096;

    localparam logic [ENTRY_W-1:0]  END_MARK  = 28'h0FFF_FFFF;
    localparam logic [ENTRY_W-1:0]  END_LIMIT = 28'h0FFF_FFF8;
    localparam logic [ENTRY_W-1:0]  FREE_MARK = 28'h000_0000;

    localparam logic [USABLE_W-1:0] RST_USABLE = 12'd4094;
    localparam logic [SECTOR_W-1:0] RST_BASE   = 32'd0;
    localparam logic [SPC_W-1:0]    RST_SPC    = 8'd8;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_SET    = 2'd1,
        OP_ALLOC  = 2'd2,
        OP_FREE   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_OUTSIDE = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USABLE = 2'd0,
        CFG_BASE   = 2'd1,
        CFG_SPC    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                  we;
        logic [TBL_AW_MAX-1:0] waddr;
        logic [ENTRY_W-1:0]    wdata;
        logic [TBL_AW_MAX-1:0] raddr;
    } t_tbl_req;

endpackage

[hdl/fce_in_if.sv]
`timescale 1ns / 1ps

interface fce_in_if;
    logic                          valid;
    logic                          ready;
    logic [fce_pkg::OP_W-1:0]      operation;
    logic [fce_pkg::ENTRY_W-1:0]   cluster_number;
    logic [fce_pkg::ENTRY_W-1:0]   entry_value;
    logic [fce_pkg::LEN_W-1:0]     chain_length;

    modport source (
        output valid, operation, cluster_number, entry_value, chain_length,
        input  ready
    );
    modport sink (
        input  valid, operation, cluster_number, entry_value, chain_length,
        output ready
    );
endinterface

[hdl/fce_out_if.sv]
`timescale 1ns / 1ps

interface fce_out_if;
    logic                          valid;
    logic                          ready;
    logic [fce_pkg::ENTRY_W-1:0]   result_cluster;
    logic [fce_pkg::SECTOR_W-1:0]  sector_address;
    logic                          chain_end;
    logic [fce_pkg::STATUS_W-1:0]  status;

    modport source (
        output valid, result_cluster, sector_address, chain_end, status,
        input  ready
    );
    modport sink (
        input  valid, result_cluster, sector_address, chain_end, status,
        output ready
    );
endinterface

[hdl/fce_table.sv]
`timescale 1ns / 1ps

module fce_table #(
    parameter int TABLE_ENTRIES = fce_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                        i_clk,
    input  fce_pkg::t_tbl_req           i_req,
    output logic [fce_pkg::ENTRY_W-1:0] o_rdata
);
    import fce_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);

    logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
        r_rdata <= mem[i_req.raddr[AW-1:0]];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/fat_cluster_chain_engine.sv]
`timescale 1ns / 1ps

// fat32 cluster chain engine
// i_in carries one request item (operation, cluster_number, entry_value,
// chain_length); o_out returns exactly one result item per request.
// i_cfg_* writes usable_clusters (0), data_base_sector (1) and
// sectors_in_cluster (2); write only while no request is in flight.
// after reset the allocation table is swept to zero, one entry a cycle;
// i_in.ready stays low during the sweep.
// one request is worked on at a time by a single sequencer around one
// table port pair (one write, one registered read per cycle); states it
// passes from the accepting edge until S_OUT loads the output register:
//   set, lookup or set outside the table, zero-length allocate  none
//   lookup   S_L_CHK (read and sector multiply, then add)
//   allocate S_A_RD+S_A_CHK per scanned entry, S_A_LINK per link, S_A_RD if dry
//   free     S_F_RD+S_F_CHK per chain entry, S_F_RD if it stops before a read
// i_in.ready returns the cycle after the result register loads, so a new
// request is only taken once the previous result has been loaded
// the result sits in an output register; the next request is accepted
// while it waits, but its result is held back until o_out is taken, so
// a stalled receiver eventually stalls i_in as well.
module fat_cluster_chain_engine #(
    parameter int TABLE_ENTRIES = fce_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fce_in_if.sink                         i_in,
    fce_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [fce_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fce_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fce_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int LW = (AW + 1 > USABLE_W + 1) ? AW + 1 : USABLE_W + 1;

    typedef enum logic [9:0] {
        S_CLR    = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_L_CHK  = 10'b00_0000_0100,
        S_A_RD   = 10'b00_0000_1000,
        S_A_CHK  = 10'b00_0001_0000,
        S_A_LINK = 10'b00_0010_0000,
        S_F_RD   = 10'b00_0100_0000,
        S_F_CHK  = 10'b00_1000_0000,
        S_OUT    = 10'b01_0000_0000,
        S_SPARE  = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [USABLE_W-1:0] r_usable;
    logic [SECTOR_W-1:0] r_base;
    logic [SPC_W-1:0]    r_spc;

    logic [AW-1:0]       r_clr, n_clr;
    logic [ENTRY_W-1:0]  r_cur, n_cur;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [LEN_W-1:0]    r_n, n_n;
    logic [LW-1:0]       r_scan, n_scan;
    logic [AW-1:0]       r_prev, n_prev;
    logic [AW-1:0]       r_first, n_first;
    logic                r_have_prev, n_have_prev;
    logic [SECTOR_W-1:0] r_prod, n_prod;

    logic [ENTRY_W-1:0]  r_res, n_res;
    logic [SECTOR_W-1:0] r_sec, n_sec;
    logic                r_end, n_end;
    logic [STATUS_W-1:0] r_st, n_st;

    logic                r_ov;
    logic [ENTRY_W-1:0]  r_o_res;
    logic [SECTOR_W-1:0] r_o_sec;
    logic                r_o_end;
    logic [STATUS_W-1:0] r_o_st;

    t_tbl_req            tbl_req;
    logic [ENTRY_W-1:0]  tbl_rdata;

    logic                in_accept;
    logic                out_load;
    logic                in_outside;
    logic [LW-1:0]       limit_usable;
    logic [LW-1:0]       limit;

    fce_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_table (
        .i_clk  (i_clk),
        .i_req  (tbl_req),
        .o_rdata(tbl_rdata)
    );

    assign i_in.ready   = (r_state == S_IDLE);
    assign in_accept    = i_in.valid && i_in.ready;
    assign in_outside   = (i_in.cluster_number >= ENTRY_W'(TABLE_ENTRIES));
    assign out_load     = (r_state == S_OUT) && (!r_ov || o_out.ready);
    assign limit_usable = LW'(r_usable) + LW'(2);
    assign limit        = (limit_usable > LW'(TABLE_ENTRIES)) ? LW'(TABLE_ENTRIES)
                                                              : limit_usable;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cur       = r_cur;
        n_len       = r_len;
        n_n         = r_n;
        n_scan      = r_scan;
        n_prev      = r_prev;
        n_first     = r_first;
        n_have_prev = r_have_prev;
        n_prod      = r_prod;
        n_res       = r_res;
        n_sec       = r_sec;
        n_end       = r_end;
        n_st        = r_st;
        tbl_req     = '0;

        case (r_state)
            S_CLR: begin
                tbl_req.we    = 1'b1;
                tbl_req.waddr = TBL_AW_MAX'(r_clr);
                tbl_req.wdata = FREE_MARK;
                n_clr         = r_clr + AW'(1);
                if (r_clr == AW'(TABLE_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                tbl_req.raddr = TBL_AW_MAX'(i_in.cluster_number[AW-1:0]);
                n_prod = 32'(({4'b0, i_in.cluster_number} - 32'd2) * {24'b0, r_spc});
                if (in_accept) begin
                    n_res       = '0;
                    n_sec       = '0;
                    n_end       = 1'b0;
                    n_st        = ST_OK;
                    n_cur       = i_in.cluster_number;
                    n_len       = i_in.chain_length;
                    n_n         = '0;
                    n_scan      = LW'(2);
                    n_first     = '0;
                    n_have_prev = 1'b0;
                    case (t_op'(i_in.operation))
                        OP_LOOKUP: begin
                            if (in_outside) begin
                                n_st    = ST_OUTSIDE;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_L_CHK;
                            end
                        end
                        OP_SET: begin
                            if (in_outside) begin
                                n_st = ST_OUTSIDE;
                            end else begin
                                tbl_req.we    = 1'b1;
                                tbl_req.waddr = TBL_AW_MAX'(i_in.cluster_number[AW-1:0]);
                                tbl_req.wdata = i_in.entry_value;
                            end
                            n_state = S_OUT;
                        end
                        OP_ALLOC: begin
                            if (i_in.chain_length == '0) begin
                                n_state = S_OUT;
                            end else begin
                                n_state = S_A_RD;
                            end
                        end
                        OP_FREE: begin
                            n_state = S_F_RD;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_L_CHK: begin
                n_res   = tbl_rdata;
                n_sec   = r_base + r_prod;
                n_end   = (tbl_rdata >= END_LIMIT);
                n_state = S_OUT;
            end
            S_A_RD: begin
                if (r_scan >= limit) begin
                    n_st    = ST_NO_FREE;
                    n_res   = ENTRY_W'(r_first);
                    n_state = S_OUT;
                end else begin
                    tbl_req.raddr = TBL_AW_MAX'(r_scan[AW-1:0]);
                    n_state       = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (tbl_rdata != FREE_MARK) begin
                    n_scan  = r_scan + LW'(1);
                    n_state = S_A_RD;
                end else begin
                    tbl_req.we    = 1'b1;
                    tbl_req.waddr = TBL_AW_MAX'(r_scan[AW-1:0]);
                    tbl_req.wdata = END_MARK;
                    n_n           = r_n + LEN_W'(1);
                    if (r_have_prev) begin
                        n_state = S_A_LINK;
                    end else begin
                        n_first     = r_scan[AW-1:0];
                        n_prev      = r_scan[AW-1:0];
                        n_have_prev = 1'b1;
                        n_scan      = r_scan + LW'(1);
                        if (r_n + LEN_W'(1) == r_len) begin
                            n_res   = ENTRY_W'(r_scan[AW-1:0]);
                            n_state = S_OUT;
                        end else begin
                            n_state = S_A_RD;
                        end
                    end
                end
            end
            S_A_LINK: begin
                tbl_req.we    = 1'b1;
                tbl_req.waddr = TBL_AW_MAX'(r_prev);
                tbl_req.wdata = ENTRY_W'(r_scan[AW-1:0]);
                n_prev        = r_scan[AW-1:0];
                n_scan        = r_scan + LW'(1);
                if (r_n == r_len) begin
                    n_res   = ENTRY_W'(r_first);
                    n_state = S_OUT;
                end else begin
                    n_state = S_A_RD;
                end
            end
            S_F_RD: begin
                if (r_cur < ENTRY_W'(2) || r_cur >= END_LIMIT) begin
                    n_state = S_OUT;
                end else if (r_cur >= ENTRY_W'(TABLE_ENTRIES)) begin
                    n_st    = ST_OUTSIDE;
                    n_state = S_OUT;
                end else begin
                    tbl_req.raddr = TBL_AW_MAX'(r_cur[AW-1:0]);
                    n_state       = S_F_CHK;
                end
            end
            S_F_CHK: begin
                tbl_req.we    = 1'b1;
                tbl_req.waddr = TBL_AW_MAX'(r_cur[AW-1:0]);
                tbl_req.wdata = FREE_MARK;
                if (tbl_rdata == FREE_MARK || tbl_rdata >= END_LIMIT) begin
                    n_state = S_OUT;
                end else begin
                    n_cur   = tbl_rdata;
                    n_state = S_F_RD;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_len       <= n_len;
        r_n         <= n_n;
        r_scan      <= n_scan;
        r_prev      <= n_prev;
        r_first     <= n_first;
        r_have_prev <= n_have_prev;
        r_prod      <= n_prod;
        r_res       <= n_res;
        r_sec       <= n_sec;
        r_end       <= n_end;
        r_st        <= n_st;
        if (out_load) begin
            r_o_res <= r_res;
            r_o_sec <= r_sec;
            r_o_end <= r_end;
            r_o_st  <= r_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_usable <= RST_USABLE;
            r_base   <= RST_BASE;
            r_spc    <= RST_SPC;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_USABLE: r_usable <= i_cfg_data[USABLE_W-1:0];
                CFG_BASE:   r_base   <= i_cfg_data[SECTOR_W-1:0];
                CFG_SPC:    r_spc    <= i_cfg_data[SPC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.result_cluster = r_o_res;
    assign o_out.sector_address = r_o_sec;
    assign o_out.chain_end      = r_o_end;
    assign o_out.status         = r_o_st;

    // clear sweep writes zeros only
    a_clr_writes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> (tbl_req.we && tbl_req.wdata == FREE_MARK))
        else $error("clear sweep write mismatch");

    // every table write stays inside the table
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_req.we |-> ({1'b0, tbl_req.waddr} < (TBL_AW_MAX + 1)'(TABLE_ENTRIES)))
        else $error("table write out of range");

    // a link write always follows a newly claimed cluster
    a_link_after_claim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_LINK) |-> ($past(r_state) == S_A_CHK && r_have_prev))
        else $error("link without claim");

    // allocation scan never touches the reserved entries
    a_scan_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_RD || r_state == S_A_CHK) |-> (r_scan >= LW'(2)))
        else $error("scan below first data cluster");

    // a finished result never carries an undefined status code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_o_st == ST_OK || r_o_st == ST_NO_FREE || r_o_st == ST_OUTSIDE))
        else $error("bad status code");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
    import fce_pkg::*;

    localparam int TBL_N = DEF_TABLE_ENTRIES;

    typedef struct packed {
        t_op                op;
        logic [ENTRY_W-1:0] cluster;
        logic [ENTRY_W-1:0] value;
        logic [LEN_W-1:0]   len;
    } t_fat_req;

    typedef struct packed {
        logic [ENTRY_W-1:0]  next_cluster;
        logic [SECTOR_W-1:0] sector;
        logic                chain_end;
        t_status             status;
    } t_fat_res;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fce_in_if  in_bus ();
    fce_out_if out_bus ();

    fat_cluster_chain_engine #(
        .TABLE_ENTRIES(TBL_N)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_bus),
        .o_out       (out_bus),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow of the allocation table and the registers
    logic [ENTRY_W-1:0]  fat_table [TBL_N];
    logic [USABLE_W-1:0] cfg_usable;
    logic [SECTOR_W-1:0] cfg_base;
    logic [SPC_W-1:0]    cfg_spc;

    t_fat_req fat_pending_q[$];
    t_fat_res fat_result_q[$];

    logic item_taken;
    int   err_count;
    int   results_seen;
    int   op_seen [4];
    int   status_seen [4];
    int   phase_count;
    int   holds_done;

    int   gap_left;
    int   burst_left;
    int   hold_left;
    int   hold_mark;
    int   pat_left;
    int   stall_pct;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_fat_res apply_fat_op(t_fat_req r);
        t_fat_res    res;
        int unsigned lim;
        int unsigned scan;
        int unsigned prev;
        int unsigned cur;
        int unsigned nxt;
        int unsigned n;
        bit          have_prev;
        bit          stop;
        res = '0;
        have_prev = 1'b0;
        stop = 1'b0;
        prev = 0;
        case (r.op)
            OP_LOOKUP: begin
                if (r.cluster >= TBL_N) begin
                    res.status = ST_OUTSIDE;
                end else begin
                    res.next_cluster = fat_table[r.cluster];
                    res.sector = cfg_base + (32'(r.cluster) - 32'd2) * 32'(cfg_spc);
                    res.chain_end = (fat_table[r.cluster] >= END_LIMIT);
                end
            end
            OP_SET: begin
                if (r.cluster >= TBL_N) res.status = ST_OUTSIDE;
                else fat_table[r.cluster] = r.value;
            end
            OP_ALLOC: begin
                lim = int'(cfg_usable) + 2;
                if (lim > TBL_N) lim = TBL_N;
                scan = 2;
                for (n = 0; n < r.len && !stop; n++) begin
                    while (scan < lim && fat_table[scan] != FREE_MARK) scan++;
                    if (scan >= lim) begin
                        res.status = ST_NO_FREE;
                        stop = 1'b1;
                    end else begin
                        fat_table[scan] = END_MARK;
                        if (have_prev) fat_table[prev] = ENTRY_W'(scan);
                        else res.next_cluster = ENTRY_W'(scan);
                        prev = scan;
                        have_prev = 1'b1;
                        scan++;
                    end
                end
            end
            default: begin
                cur = 32'(r.cluster);
                while (!stop && cur >= 2 && cur < END_LIMIT) begin
                    if (cur >= TBL_N) begin
                        res.status = ST_OUTSIDE;
                        stop = 1'b1;
                    end else begin
                        nxt = 32'(fat_table[cur]);
                        fat_table[cur] = FREE_MARK;
                        if (nxt == 0 || nxt >= END_LIMIT) stop = 1'b1;
                        else cur = nxt;
                    end
                end
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t ns: %s", $time, what);
        err_count++;
    endtask

    // sender: bursts of items with random gaps
    always @(negedge i_clk) begin : driver
        t_fat_req nxt;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || item_taken) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                in_bus.valid <= 1'b0;
            end else if (fat_pending_q.size() > 0) begin
                nxt = fat_pending_q.pop_front();
                in_bus.valid          <= 1'b1;
                in_bus.operation      <= nxt.op;
                in_bus.cluster_number <= nxt.cluster;
                in_bus.entry_value    <= nxt.value;
                in_bus.chain_length   <= nxt.len;
                if (burst_left > 0) begin
                    burst_left = burst_left - 1;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
                end
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern plus occasional long hold-off
    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_bus.ready <= 1'b0;
        end else if (results_seen >= hold_mark) begin
            hold_left = 500;
            hold_mark = hold_mark + 600;
            holds_done++;
            out_bus.ready <= 1'b0;
        end else begin
            if (pat_left == 0) begin
                pat_left = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end else begin
                pat_left = pat_left - 1;
            end
            out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_fat_req req;
        t_fat_res want;
        t_fat_res got;
        if (!i_rst_n) begin
            item_taken <= 1'b0;
        end else begin
            item_taken <= in_bus.valid && in_bus.ready;
            if (out_bus.valid && out_bus.ready) begin
                results_seen++;
                if (fat_result_q.size() == 0) begin
                    report_mismatch("result item with none pending");
                end else begin
                    want = fat_result_q.pop_front();
                    if (out_bus.result_cluster !== want.next_cluster)
                        report_mismatch($sformatf("result_cluster %h, want %h",
                            out_bus.result_cluster, want.next_cluster));
                    if (out_bus.sector_address !== want.sector)
                        report_mismatch($sformatf("sector_address %h, want %h",
                            out_bus.sector_address, want.sector));
                    if (out_bus.chain_end !== want.chain_end)
                        report_mismatch($sformatf("chain_end %b, want %b",
                            out_bus.chain_end, want.chain_end));
                    if (out_bus.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                            out_bus.status, want.status));
                end
            end
            if (in_bus.valid && in_bus.ready) begin
                req.op      = t_op'(in_bus.operation);
                req.cluster = in_bus.cluster_number;
                req.value   = in_bus.entry_value;
                req.len     = in_bus.chain_length;
                got = apply_fat_op(req);
                fat_result_q.push_back(got);
                op_seen[req.op]++;
                status_seen[got.status]++;
            end
        end
    end

    function automatic void queue_fat_req(t_op op, logic [ENTRY_W-1:0] cl,
                                          logic [ENTRY_W-1:0] val, logic [LEN_W-1:0] len);
        t_fat_req r;
        r.op = op;
        r.cluster = cl;
        r.value = val;
        r.len = len;
        fat_pending_q.push_back(r);
    endfunction

    function automatic t_fat_req random_fat_req(bit short_len);
        t_fat_req    r;
        int unsigned pick;
        int unsigned span;
        int unsigned len_top;
        span = int'(cfg_usable) + 3;
        len_top = (span > TBL_N) ? TBL_N - 1 : span - 1;
        pick = $urandom_range(0, 99);
        if (pick < 30) r.op = OP_LOOKUP;
        else if (pick < 45) r.op = OP_SET;
        else if (pick < 75) r.op = OP_ALLOC;
        else r.op = OP_FREE;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            r.cluster = ENTRY_W'($urandom_range(0, span));
        end else if (pick < 90) begin
            r.cluster = ENTRY_W'($urandom_range(0, TBL_N - 1));
        end else if (pick < 95) begin
            r.cluster = ENTRY_W'($urandom_range(TBL_N, 32'h0FFF_FFFF));
        end else begin
            case ($urandom_range(0, 4))
                0: r.cluster = END_LIMIT - 1;
                1: r.cluster = END_LIMIT;
                2: r.cluster = END_MARK;
                3: r.cluster = 1;
                default: r.cluster = ENTRY_W'(TBL_N);
            endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 40) r.value = ENTRY_W'($urandom_range(2, span));
        else if (pick < 60) r.value = FREE_MARK;
        else if (pick < 75) r.value = END_LIMIT + ENTRY_W'($urandom_range(0, 7));
        else if (pick < 90) r.value = ENTRY_W'($urandom_range(TBL_N, 32'h0FFF_FFF7));
        else r.value = ENTRY_W'($urandom);
        pick = $urandom_range(0, 99);
        if (short_len) r.len = LEN_W'($urandom_range(0, 8));
        else if (pick < 50) r.len = LEN_W'($urandom_range(1, 4));
        else if (pick < 75) r.len = LEN_W'($urandom_range(0, 16));
        else if (pick < 90) r.len = LEN_W'($urandom_range(0, len_top));
        else r.len = LEN_W'($urandom_range(0, 4095));
        return r;
    endfunction

    task automatic wait_drained();
        while (fat_pending_q.size() != 0 || fat_result_q.size() != 0 || in_bus.valid)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_USABLE: cfg_usable = data[USABLE_W-1:0];
            CFG_BASE:   cfg_base = data;
            default:    cfg_spc = data[SPC_W-1:0];
        endcase
    endtask

    task automatic set_phase(int unsigned usable, logic [31:0] base, int unsigned spc);
        wait_drained();
        write_reg(CFG_USABLE, usable);
        write_reg(CFG_BASE, base);
        write_reg(CFG_SPC, spc);
        phase_count++;
    endtask

    initial begin : stimulus
        int          k;
        int unsigned usable;
        logic [31:0] base;
        int unsigned spc;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_USABLE;
        i_cfg_data = '0;
        in_bus.valid = 1'b0;
        in_bus.operation = OP_LOOKUP;
        in_bus.cluster_number = '0;
        in_bus.entry_value = '0;
        in_bus.chain_length = '0;
        out_bus.ready = 1'b0;
        for (k = 0; k < TBL_N; k++) fat_table[k] = FREE_MARK;
        cfg_usable = RST_USABLE;
        cfg_base = RST_BASE;
        cfg_spc = RST_SPC;
        err_count = 0;
        results_seen = 0;
        phase_count = 1;
        holds_done = 0;
        gap_left = 0;
        burst_left = 0;
        hold_left = 0;
        hold_mark = 200;
        pat_left = 0;
        stall_pct = 0;
        for (k = 0; k < 4; k++) begin
            op_seen[k] = 0;
            status_seen[k] = 0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // low clusters, table edge, end markers, loops and walks off the table
        queue_fat_req(OP_LOOKUP, 0, 0, 0);
        queue_fat_req(OP_LOOKUP, 1, 0, 0);
        queue_fat_req(OP_LOOKUP, ENTRY_W'(TBL_N - 1), 0, 0);
        queue_fat_req(OP_LOOKUP, ENTRY_W'(TBL_N), 0, 0);
        queue_fat_req(OP_LOOKUP, END_MARK, END_MARK, 12'hFFF);
        queue_fat_req(OP_SET, ENTRY_W'(TBL_N - 1), END_MARK, 0);
        queue_fat_req(OP_LOOKUP, ENTRY_W'(TBL_N - 1), 0, 0);
        queue_fat_req(OP_SET, 3, END_LIMIT - 1, 0);
        queue_fat_req(OP_LOOKUP, 3, 0, 0);
        queue_fat_req(OP_SET, 28'h800_0000, 28'h123_4567, 0);
        queue_fat_req(OP_SET, 0, 5, 0);
        queue_fat_req(OP_SET, 1, END_LIMIT, 0);
        queue_fat_req(OP_ALLOC, 0, 0, 0);
        queue_fat_req(OP_ALLOC, 0, 0, 3);
        queue_fat_req(OP_LOOKUP, 2, 0, 0);
        queue_fat_req(OP_FREE, 0, 0, 0);
        queue_fat_req(OP_FREE, 1, 0, 0);
        queue_fat_req(OP_FREE, END_LIMIT, 0, 0);
        queue_fat_req(OP_FREE, END_MARK, 0, 0);
        queue_fat_req(OP_FREE, 2, 0, 0);
        queue_fat_req(OP_SET, 10, 4200, 0);
        queue_fat_req(OP_FREE, 10, 0, 0);
        queue_fat_req(OP_SET, 20, 21, 0);
        queue_fat_req(OP_SET, 21, 20, 0);
        queue_fat_req(OP_FREE, 20, 0, 0);
        queue_fat_req(OP_SET, 3, FREE_MARK, 0);
        // fill the whole table, then run dry
        queue_fat_req(OP_ALLOC, 0, 0, 12'hFFF);
        queue_fat_req(OP_ALLOC, 0, 0, 1);
        queue_fat_req(OP_LOOKUP, ENTRY_W'(TBL_N - 2), 0, 0);
        queue_fat_req(OP_FREE, 2, 0, 0);

        set_phase(0, 32'hFFFF_FFFF, 0);
        repeat (40) fat_pending_q.push_back(random_fat_req(1'b0));

        set_phase(4095, $urandom, 255);
        repeat (30) fat_pending_q.push_back(random_fat_req(1'b1));
        queue_fat_req(OP_ALLOC, 0, 0, 12'hFFF);
        queue_fat_req(OP_FREE, 2, 0, 0);

        for (k = 0; k < 12; k++) begin
            usable = (k == 6) ? 400 : $urandom_range(4, 120);
            base = (k == 2) ? 32'd0 : (k == 3) ? 32'hFFFF_FFFF : $urandom;
            case (k)
                0: spc = 1;
                1: spc = 128;
                4: spc = 0;
                5: spc = 255;
                default: spc = $urandom_range(1, 128);
            endcase
            set_phase(usable, base, spc);
            repeat (100) fat_pending_q.push_back(random_fat_req(1'b0));
        end

        wait_drained();
        repeat (30) @(negedge i_clk);
        $display("covered %0d items: lookup %0d, set %0d, allocate %0d, free %0d, %0d settings",
                 op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
                 op_seen[OP_LOOKUP], op_seen[OP_SET], op_seen[OP_ALLOC], op_seen[OP_FREE],
                 phase_count);
        $display("status ok %0d, no free %0d, outside %0d; long receiver hold-offs %0d",
                 status_seen[ST_OK], status_seen[ST_NO_FREE], status_seen[ST_OUTSIDE],
                 holds_done);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #200_000_000;
        $display("timeout with %0d results still pending", fat_result_q.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
